FILE: hw/rtl/fwna_pkg.sv
// Shared types, character constants and digit helpers for the number-to-ASCII formatter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package fwna_pkg;

    // Format opcodes carried in the input item.
    localparam logic [1:0] OP_BYTE_DEC = 2'd0;
    localparam logic [1:0] OP_BYTE_HEX = 2'd1;
    localparam logic [1:0] OP_WORD_DEC = 2'd2;
    localparam logic [1:0] OP_WORD_HEX = 2'd3;

    // ASCII codes used by the formatter.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [3:0] HEX_TEN   = 4'h0A;

    // One classified job as it travels from the front to the back.
    typedef struct packed {
        logic        hex;    // 1 for "0x" hex output, 0 for decimal
        logic [2:0]  left;   // characters still to send, minus one
        logic [15:0] val;    // value, aligned so the first hex nibble is on top
    } t_job;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Result of one decimal digit step.
    typedef struct packed {
        logic [3:0]  digit;
        logic [15:0] rest;
    } t_dig;

    // Upper-case ASCII for one hex nibble.
    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < HEX_TEN) begin
            ch = CH_ZERO + {4'd0, nib};
        end else begin
            ch = CH_UPPER_A + {4'd0, nib - HEX_TEN};
        end
        return ch;
    endfunction

    // Power of ten for a digit position, 0 for ones up to 4 for ten-thousands.
    function automatic logic [16:0] pow10(input logic [2:0] idx);
        logic [16:0] p;
        case (idx)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            default: p = 17'd0;
        endcase
        return p;
    endfunction

    // One decimal digit: compare the rest against the nine multiples of the power in parallel.
    function automatic t_dig dec_step(input logic [15:0] v, input logic [2:0] idx);
        t_dig        r;
        logic [16:0] p;
        logic [16:0] cand;
        logic [16:0] sub;
        p = pow10(idx);
        r.digit = 4'd0;
        sub = 17'd0;
        for (int i = 1; i <= 9; i++) begin
            cand = 17'(i * p);
            if ({1'b0, v} >= cand) begin
                r.digit = 4'(i);
                sub = cand;
            end
        end
        r.rest = 16'({1'b0, v} - sub);
        return r;
    endfunction

endpackage

FILE: hw/rtl/fwna_queue.sv
// Two-entry job queue between the front and the back of the formatter.
// Depends on fwna_pkg for the job and status types.
`timescale 1ns / 1ps

module fwna_queue
    import fwna_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_stat
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    // Guard the handshake against a full or an empty queue.
    assign w_push = i_push && (r_cnt != 2'd2);
    assign w_pop  = i_pop && (r_cnt != 2'd0);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

FILE: hw/rtl/fwna_front.sv
// Front of the formatter: accepts input transfers, holds the enable register, classifies jobs.
// Depends on fwna_pkg for opcodes and the job type.
`timescale 1ns / 1ps

module fwna_front
    import fwna_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_value,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_job        o_job
);

    logic r_port_en;

    // Enable register; a write is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_en <= 1'b0;
        end else if (i_cfg_valid) begin
            r_port_en <= i_cfg_data[0];
        end
    end

    // Items are taken whenever the queue has room; disabled items are dropped here.
    assign o_s_tready = !i_qstat.full;
    assign o_push     = i_s_tvalid && !i_qstat.full && r_port_en;

    // Classify the opcode into a character count and an aligned value.
    always_comb begin
        unique case (i_opcode)
            OP_BYTE_DEC: begin
                o_job.hex  = 1'b0;
                o_job.left = 3'd2;
                o_job.val  = {8'd0, i_value[7:0]};
            end
            OP_BYTE_HEX: begin
                o_job.hex  = 1'b1;
                o_job.left = 3'd3;
                o_job.val  = {i_value[7:0], 8'd0};
            end
            OP_WORD_DEC: begin
                o_job.hex  = 1'b0;
                o_job.left = 3'd4;
                o_job.val  = i_value;
            end
            default: begin
                o_job.hex  = 1'b1;
                o_job.left = 3'd5;
                o_job.val  = i_value;
            end
        endcase
    end

endmodule

FILE: hw/rtl/fwna_back.sv
// Back end: turns one queued job into characters in an output register, one per cycle unless stalled.
// Depends on fwna_pkg for the job type and the digit helpers.
`timescale 1ns / 1ps

module fwna_back
    import fwna_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_character,
    output logic       o_last
);

    logic        r_busy;
    logic        r_hex;
    logic [2:0]  r_pos;
    logic [2:0]  r_left;
    logic [15:0] r_val;
    logic        r_oval;
    logic [7:0]  r_char;
    logic        r_last;

    logic        w_adv;
    logic        w_emit;
    logic [7:0]  n_char;
    logic [15:0] n_val;
    t_dig        w_dig;

    // The output register can be reloaded when empty or when its transfer completes.
    assign w_adv  = !r_oval || i_m_tready;
    assign w_emit = r_busy && w_adv;
    assign o_pop  = w_adv && (!r_busy || (r_left == 3'd0)) && !i_qstat.empty;

    // Next character and the value left after it.
    assign w_dig = dec_step(r_val, r_left);

    always_comb begin
        if (r_hex) begin
            if (r_pos == 3'd0) begin
                n_char = CH_ZERO;
                n_val  = r_val;
            end else if (r_pos == 3'd1) begin
                n_char = CH_X;
                n_val  = r_val;
            end else begin
                n_char = hex_ascii(r_val[15:12]);
                n_val  = {r_val[11:0], 4'd0};
            end
        end else begin
            n_char = CH_ZERO + {4'd0, w_dig.digit};
            n_val  = w_dig.rest;
        end
    end

    // Job sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (w_emit && (r_left == 3'd0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hex  <= i_job.hex;
            r_pos  <= 3'd0;
            r_left <= i_job.left;
            r_val  <= i_job.val;
        end else if (w_emit) begin
            r_pos  <= r_pos + 3'd1;
            r_left <= r_left - 3'd1;
            r_val  <= n_val;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_adv) begin
            r_oval <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= n_char;
            r_last <= (r_left == 3'd0);
        end
    end

    assign o_m_tvalid  = r_oval;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

FILE: hw/rtl/fixed_width_number_to_ascii.sv
// Top level of the number-to-ASCII formatter: front, two-entry job queue and back.
// Depends on fwna_pkg, fwna_front, fwna_queue and fwna_back.
`timescale 1ns / 1ps

// Each input transfer carries a format opcode and a 16-bit value; the block sends the
// value's ASCII characters most significant first and flags the final one on tlast.
// Byte decimal gives 3 characters, byte hex 4 ("0x" and two digits), word decimal 5
// and word hex 6, sent one character per cycle unless the output stalls, paced by the
// back's one-digit-per-cycle conversion step. Inputs are taken in consecutive cycles
// until the two-entry job queue fills. While the enable register
// is 0, input transfers are still taken but produce no characters. The enable register
// is written through the cfg channel, which is always ready, and resets to 0.
module fixed_width_number_to_ascii
    import fwna_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write: bit 0 is port_enabled.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data,
    // Input stream; tdata fields from bit 0: opcode[1:0], value[17:2], zero fill.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,
    // Output stream; tdata fields from bit 0: character[7:0]; tlast is last.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    t_job   w_in_job;
    t_job   w_out_job;
    t_qstat w_qstat;
    logic   w_push;
    logic   w_pop;

    // Accept and classify.
    fwna_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_opcode    (i_s_tdata[1:0]),
        .i_value     (i_s_tdata[17:2]),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_job       (w_in_job)
    );

    // Job queue between the two sides.
    fwna_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .i_pop   (w_pop),
        .o_job   (w_out_job),
        .o_stat  (w_qstat)
    );

    // Character generation.
    fwna_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_out_job),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_character (o_m_tdata),
        .o_last      (o_m_tlast)
    );

    // The queue never reports full and empty at once.
    a_qstat_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("queue status is both full and empty");

    // A character that is not the last of its number is followed at once by the next.
    a_no_gap_in_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("gap inside a number's characters");

    // The front never pushes into a full queue that is not draining.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full && !w_pop))
        else $error("push into a full queue");

endmodule
